// File: src/mono_framebuffer_block_packer_macros.svh
// Assertion macros used by the framebuffer block packer's output side (mfbp_back).
`ifndef MONO_FRAMEBUFFER_BLOCK_PACKER_MACROS_SVH
`define MONO_FRAMEBUFFER_BLOCK_PACKER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MFBP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MFBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mfbp_pkg.sv
// Types, constants and helper functions of the framebuffer block packer.
package mfbp_pkg;

   localparam int unsigned DEF_MAX_WIDTH  = 1024;
   localparam int unsigned DEF_MAX_HEIGHT = 1024;

   localparam int unsigned FB_W        = 8;
   // Wide enough for the largest dimension plus an offset.
   localparam int unsigned DIM_W       = 13;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_COL_OFFSET = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_OFFSET = CSR_INDEX_W'(3);

   localparam logic [10:0] RST_WIDTH  = 11'd300;
   localparam logic [10:0] RST_HEIGHT = 11'd300;

   // Reciprocal of three scaled by 2^16, rounded up.
   localparam logic [15:0] RECIP_THREE = 16'd21846;

   typedef struct packed {
      logic [10:0] width_px;
      logic [10:0] height_px;
      logic [7:0]  col_offset;
      logic [7:0]  row_offset;
   } cfg_type;

   typedef struct packed {
      logic            frame_start;
      logic            odd_row;
      logic            two_blocks;
      logic            last_byte;
      logic            in_store;
      logic [FB_W-1:0] fb_byte;
   } item_type;

   function automatic int unsigned addr_bits(input int unsigned depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                  input logic [DIM_W-1:0] lo,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] v;
      v = raw;
      if (raw < lo) begin
         v = lo;
      end else if (raw > hi) begin
         v = hi;
      end
      return v;
   endfunction

   // x / 12 as (x / 4) / 3; the reciprocal error stays far below one step for
   // every value that fits DIM_W bits.
   function automatic logic [7:0] div_twelve(input logic [DIM_W-1:0] x);
      logic [DIM_W-3:0]    quarter;
      logic [DIM_W+13:0]   prod;
      quarter = x[DIM_W-1:2];
      prod    = quarter * RECIP_THREE;
      return prod[23:16];
   endfunction

   // Packs four columns of two rows; the leftmost pixel pair lands in bits 7 and 6.
   function automatic logic [7:0] pack_block(input logic [7:0] top,
                                             input logic [7:0] bot,
                                             input logic       low_half);
      logic [3:0] t;
      logic [3:0] b;
      t = low_half ? top[3:0] : top[7:4];
      b = low_half ? bot[3:0] : bot[7:4];
      return {t[3], b[3], t[2], b[2], t[1], b[1], t[0], b[0]};
   endfunction

endpackage

// File: src/mfbp_req_if.sv
// Framebuffer byte channel.
interface mfbp_req_if;
   import mfbp_pkg::*;
   logic            valid;
   logic            ready;
   logic [FB_W-1:0] fb_byte;
   modport source (output valid, output fb_byte, input ready);
   modport sink (input valid, input fb_byte, output ready);
endinterface

// File: src/mfbp_rsp_if.sv
// Panel byte stream channel.
interface mfbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] spi_byte;
   logic       is_data;
   logic       end_of_burst;
   logic       last_of_item;
   modport source (output valid, output spi_byte, output is_data, output end_of_burst,
                   output last_of_item, input ready);
   modport sink (input valid, input spi_byte, input is_data, input end_of_burst,
                 input last_of_item, output ready);
endinterface

// File: src/mfbp_csr_if.sv
// Register write channel.
interface mfbp_csr_if;
   import mfbp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/mfbp_regs.sv
// Configuration registers of the framebuffer block packer.
module mfbp_regs (
   input  logic              clock,
   input  logic              reset,
   mfbp_csr_if.sink          csr,
   output mfbp_pkg::cfg_type cfg
);
   import mfbp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_WIDTH:      cfg_in.width_px   = csr.data;
            REG_HEIGHT:     cfg_in.height_px  = csr.data;
            REG_COL_OFFSET: cfg_in.col_offset = csr.data[7:0];
            REG_ROW_OFFSET: cfg_in.row_offset = csr.data[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_px   <= RST_WIDTH;
         cfg_ff.height_px  <= RST_HEIGHT;
         cfg_ff.col_offset <= 8'd0;
         cfg_ff.row_offset <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/mfbp_front.sv
// Input side: tracks the framebuffer position and classifies each item.
module mfbp_front #(
   parameter int unsigned MAX_WIDTH  = mfbp_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = mfbp_pkg::DEF_MAX_HEIGHT,
   parameter int unsigned ADDR_W     = 7
) (
   input  logic               clock,
   input  logic               reset,
   mfbp_req_if.sink           req,
   input  mfbp_pkg::cfg_type  cfg,
   input  logic               full,
   output logic               push,
   output mfbp_pkg::item_type item,
   output logic [ADDR_W-1:0]  addr
);
   import mfbp_pkg::*;

   localparam int unsigned STRIDE_MAX  = (MAX_WIDTH + 7) / 8;
   localparam int unsigned STORE_DEPTH = MAX_WIDTH / 8;
   localparam int unsigned COL_W       = $clog2(STRIDE_MAX + 1);
   localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
   localparam int unsigned WW          = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW          = $clog2(MAX_HEIGHT + 1);

   logic [DIM_W-1:0] width_full;
   logic [DIM_W-1:0] height_full;
   logic [WW-1:0]    width_eff;
   logic [WW:0]      width_round;
   logic [HW-1:0]    height_eff;
   logic [COL_W-1:0] stride;
   logic [COL_W-1:0] col_ff, col_in, col_cur, col_next;
   logic [ROW_W-1:0] row_ff, row_in, row_cur, row_next;
   logic [HW-1:0]    row_inc;
   logic             restart;
   logic             last;

   always_comb begin
      width_full  = clamp_dim(DIM_W'({cfg.width_px[10:2], 2'b00}), DIM_W'(4),
                              DIM_W'(MAX_WIDTH));
      height_full = clamp_dim(DIM_W'({cfg.height_px[10:1], 1'b0}), DIM_W'(2),
                              DIM_W'(MAX_HEIGHT));
      width_eff   = width_full[WW-1:0];
      height_eff  = height_full[HW-1:0];
      width_round = {1'b0, width_eff} + (WW + 1)'(7);
      stride      = COL_W'(width_round >> 3);

      // A width or height change can leave the position outside the frame.
      restart = (col_ff >= stride) || (HW'(row_ff) >= height_eff);
      col_cur = restart ? '0 : col_ff;
      row_cur = restart ? '0 : row_ff;
      last    = (COL_W'(col_cur + 1'b1) == stride);
      row_inc = HW'(row_cur) + HW'(1);

      if (last) begin
         col_next = '0;
         row_next = (row_inc >= height_eff) ? '0 : ROW_W'(row_inc);
      end else begin
         col_next = COL_W'(col_cur + 1'b1);
         row_next = row_cur;
      end

      item.frame_start = (col_cur == '0) && (row_cur == '0);
      item.odd_row     = row_cur[0];
      // Only the last byte of a row can hold just four pixels.
      item.two_blocks  = !(last && width_eff[2]);
      item.last_byte   = last;
      item.in_store    = (col_cur < COL_W'(STORE_DEPTH));
      item.fb_byte     = req.fb_byte;
      addr             = col_cur[ADDR_W-1:0];

      push      = req.valid && !full;
      req.ready = !full;
      col_in    = push ? col_next : col_ff;
      row_in    = push ? row_next : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: src/mfbp_queue.sv
// Short queue of classified items between the input and output sides.
module mfbp_queue #(
   parameter int unsigned ADDR_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mfbp_pkg::item_type push_item,
   input  logic [ADDR_W-1:0]  push_addr,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output mfbp_pkg::item_type head_item,
   output logic [ADDR_W-1:0]  head_addr
);
   import mfbp_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   item_type          items_ff [QUEUE_DEPTH];
   logic [ADDR_W-1:0] addrs_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;

   always_comb begin
      full      = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head_item = items_ff[rd_ptr_ff];
      head_addr = addrs_ff[rd_ptr_ff];
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = (PTR_W + 1)'(count_ff + 1'b1);
         2'b01:   count_in = (PTR_W + 1)'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         items_ff[wr_ptr_ff] <= push_item;
         addrs_ff[wr_ptr_ff] <= push_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/mfbp_back.sv
// Output side: holds the line store and sequences command and pixel bytes.
`include "mono_framebuffer_block_packer_macros.svh"

module mfbp_back #(
   parameter int unsigned MAX_WIDTH  = mfbp_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = mfbp_pkg::DEF_MAX_HEIGHT,
   parameter int unsigned ADDR_W     = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  mfbp_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  mfbp_pkg::item_type q_item,
   input  logic [ADDR_W-1:0]  q_addr,
   output logic               pop,
   mfbp_rsp_if.source         rsp
);
   import mfbp_pkg::*;

   localparam int unsigned STORE_DEPTH = MAX_WIDTH / 8;

   typedef enum logic [3:0] {
      PH_COL_CMD,
      PH_COL_START,
      PH_COL_END,
      PH_ROW_CMD,
      PH_ROW_START,
      PH_ROW_END,
      PH_WRITE_CMD,
      PH_DATA_HI,
      PH_DATA_LO
   } phase_type;

   logic [7:0]       store_mem [STORE_DEPTH];
   logic [7:0]       top_ff;
   logic [7:0]       top_byte;

   phase_type        phase_ff, phase_in, phase_step, phase_last;
   logic             active_ff, active_in;
   item_type         cur_ff, cur_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       spi_byte_ff, spi_byte_in;
   logic             is_data_ff, is_data_in;
   logic             eob_ff, eob_in;
   logic             last_ff, last_in;

   logic [DIM_W-1:0] width_full;
   logic [DIM_W-1:0] height_full;
   logic [DIM_W-1:0] col_end_sum;
   logic [DIM_W-1:0] row_end_sum;
   logic [7:0]       sel_byte;
   logic             sel_data;
   logic             sel_eob;
   logic             load;
   logic             finish;

   always_comb begin
      width_full  = clamp_dim(DIM_W'({cfg.width_px[10:2], 2'b00}), DIM_W'(4),
                              DIM_W'(MAX_WIDTH));
      height_full = clamp_dim(DIM_W'({cfg.height_px[10:1], 1'b0}), DIM_W'(2),
                              DIM_W'(MAX_HEIGHT));
      col_end_sum = DIM_W'(cfg.col_offset) + width_full - DIM_W'(1);
      row_end_sum = DIM_W'(cfg.row_offset) + height_full - DIM_W'(1);
      top_byte    = cur_ff.in_store ? top_ff : 8'd0;

      phase_last = !cur_ff.odd_row ? PH_WRITE_CMD
                 : (cur_ff.two_blocks ? PH_DATA_LO : PH_DATA_HI);

      unique case (phase_ff)
         PH_COL_CMD:   phase_step = PH_COL_START;
         PH_COL_START: phase_step = PH_COL_END;
         PH_COL_END:   phase_step = PH_ROW_CMD;
         PH_ROW_CMD:   phase_step = PH_ROW_START;
         PH_ROW_START: phase_step = PH_ROW_END;
         PH_ROW_END:   phase_step = PH_WRITE_CMD;
         PH_WRITE_CMD: phase_step = PH_DATA_HI;
         PH_DATA_HI:   phase_step = PH_DATA_LO;
         default:      phase_step = PH_DATA_LO;
      endcase

      sel_data = 1'b1;
      sel_eob  = 1'b1;
      unique case (phase_ff)
         PH_COL_CMD: begin
            sel_byte = CMD_COLUMN_SET;
            sel_data = 1'b0;
         end
         PH_COL_START: sel_byte = div_twelve(DIM_W'(cfg.col_offset));
         PH_COL_END:   sel_byte = div_twelve(col_end_sum);
         PH_ROW_CMD: begin
            sel_byte = CMD_ROW_SET;
            sel_data = 1'b0;
         end
         PH_ROW_START: sel_byte = {1'b0, cfg.row_offset[7:1]};
         PH_ROW_END:   sel_byte = row_end_sum[8:1];
         PH_WRITE_CMD: begin
            sel_byte = CMD_MEMORY_WRITE;
            sel_data = 1'b0;
         end
         PH_DATA_HI: begin
            sel_byte = pack_block(top_byte, cur_ff.fb_byte, 1'b0);
            sel_eob  = cur_ff.last_byte && !cur_ff.two_blocks;
         end
         PH_DATA_LO: begin
            sel_byte = pack_block(top_byte, cur_ff.fb_byte, 1'b1);
            sel_eob  = cur_ff.last_byte;
         end
         default: begin
            sel_byte = 8'd0;
            sel_data = 1'b0;
         end
      endcase

      load   = active_ff && (!rsp_valid_ff || rsp.ready);
      finish = load && (phase_ff == phase_last);
      pop    = q_valid && (!active_ff || finish);

      active_in = active_ff;
      cur_in    = cur_ff;
      phase_in  = phase_ff;
      if (pop) begin
         // Even-row items that do not start a frame only fill the line store.
         active_in = q_item.frame_start || q_item.odd_row;
         cur_in    = q_item;
         phase_in  = q_item.frame_start ? PH_COL_CMD : PH_DATA_HI;
      end else if (finish) begin
         active_in = 1'b0;
      end else if (load) begin
         phase_in = phase_step;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      spi_byte_in = load ? sel_byte : spi_byte_ff;
      is_data_in  = load ? sel_data : is_data_ff;
      eob_in      = load ? sel_eob : eob_ff;
      last_in     = load ? (phase_ff == phase_last) : last_ff;

      rsp.valid        = rsp_valid_ff;
      rsp.spi_byte     = spi_byte_ff;
      rsp.is_data      = is_data_ff;
      rsp.end_of_burst = eob_ff;
      rsp.last_of_item = last_ff;
   end

   always_ff @(posedge clock) begin
      if (pop && q_item.in_store) begin
         if (q_item.odd_row) begin
            top_ff <= store_mem[q_addr];
         end else begin
            store_mem[q_addr] <= q_item.fb_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         phase_ff     <= PH_COL_CMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      spi_byte_ff <= spi_byte_in;
      is_data_ff  <= is_data_in;
      eob_ff      <= eob_in;
      last_ff     <= last_in;
   end

   `MFBP_ASSERT_IMPLIES(a_cmd_closes_burst, clock, reset, rsp_valid_ff && !is_data_ff, eob_ff, "command byte does not close its burst")
   `MFBP_ASSERT_IMPLIES(a_data_on_odd_row, clock, reset, active_ff && (phase_ff == PH_DATA_HI || phase_ff == PH_DATA_LO), cur_ff.odd_row, "pixel phase on an even-row item")
   `MFBP_ASSERT_IMPLIES(a_low_half_needs_two, clock, reset, active_ff && phase_ff == PH_DATA_LO, cur_ff.two_blocks, "second block emitted for a four-pixel tail")
   `MFBP_ASSERT_NEXT(a_finish_retires, clock, reset, finish && !pop, !active_ff, "item still active after its last byte")

endmodule

// File: src/mono_framebuffer_block_packer.sv
// Converts a 1-bit-per-pixel framebuffer, one byte per item, into the panel's
// byte stream of 4x2 pixel blocks. The first item of a frame is preceded by the
// seven address-window command bytes; even-row items are kept in a line store and
// produce nothing, and each odd-row item produces one or two packed bytes. Items
// enter a four-entry queue, so the input keeps flowing while the output stalls,
// until the queue is full. The output register delivers one byte per cycle while
// the receiver is ready, which sets the rate: an odd-row item yields two bytes
// (one for a four-pixel row tail) and an even-row item none. The line store
// needs no clearing after reset.
module mono_framebuffer_block_packer #(
   parameter int unsigned MAX_WIDTH  = mfbp_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = mfbp_pkg::DEF_MAX_HEIGHT
) (
   input logic        clock,
   input logic        reset,
   mfbp_req_if.sink   req_ch,
   mfbp_rsp_if.source rsp_ch,
   mfbp_csr_if.sink   csr_ch
);
   import mfbp_pkg::*;

   localparam int unsigned ADDR_W = addr_bits(MAX_WIDTH / 8);

   cfg_type           cfg;
   item_type          push_item;
   item_type          head_item;
   logic [ADDR_W-1:0] push_addr;
   logic [ADDR_W-1:0] head_addr;
   logic              push;
   logic              pop;
   logic              full;
   logic              not_empty;

   mfbp_regs u_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   mfbp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .cfg   (cfg),
      .full  (full),
      .push  (push),
      .item  (push_item),
      .addr  (push_addr)
   );

   mfbp_queue #(
      .ADDR_W (ADDR_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .push_addr (push_addr),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item),
      .head_addr (head_addr)
   );

   mfbp_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (not_empty),
      .q_item  (head_item),
      .q_addr  (head_addr),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule
